@@ hdl/packbits_row_encoder_top_assert.svh @@
// assertion macros for the packbits row encoder checker
// no dependencies; included by the checker file
`ifndef PACKBITS_ROW_ENCODER_TOP_ASSERT_SVH
`define PACKBITS_ROW_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PBRE_ASSERT_NOW(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PBRE_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pbre_pkg.sv @@
// shared constants, types and command/status structs of the packbits row encoder
// no dependencies
package pbre_pkg;

    localparam int MAX_RUN = 128;
    localparam int CNT_W   = $clog2(MAX_RUN + 1);
    localparam int ADDR_W  = (MAX_RUN > 2) ? $clog2(MAX_RUN) : 1;
    localparam int BYTE_W  = 8;
    localparam int LANES   = 4;
    localparam int WORD_W  = BYTE_W * LANES;
    localparam int LANE_W  = $clog2(LANES);
    localparam int BCNT_W  = 3;
    localparam int ROW_W   = 16;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [BCNT_W-1:0] bcnt_t;
    typedef logic [ROW_W-1:0]  row_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_LHDR,
        EMIT_LBYTE,
        EMIT_RHDR,
        EMIT_RVAL
    } emit_sel_t;

    typedef struct packed {
        logic      latch;
        logic      upd;
        logic      push;
        logic      grp_clr;
        logic      finish;
        emit_sel_t emit_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic diff_close;
        logic run_nz;
        logic repeat_close;
        logic lit_nz;
        logic cap_next;
        logic last;
        logic lb_last;
        logic push_last;
        logic emit_ok;
        logic end_done;
    } dp_status_t;

endpackage

@@ hdl/pbre_in_if.sv @@
// input channel of the packbits row encoder: one pixel byte per item
// depends on pbre_pkg
interface pbre_in_if;
    logic          valid;
    logic          ready;
    pbre_pkg::byte_t data_byte;
    logic          last_in_row;

    modport source (output valid, output data_byte, output last_in_row, input ready);
    modport sink (input valid, input data_byte, input last_in_row, output ready);
endinterface

@@ hdl/pbre_out_if.sv @@
// output channel of the packbits row encoder: up to four encoded bytes per item
// depends on pbre_pkg
interface pbre_out_if;
    logic            valid;
    logic            ready;
    pbre_pkg::word_t out_word;
    pbre_pkg::bcnt_t byte_count;
    logic            last_of_step;
    logic            row_done;
    pbre_pkg::row_t  row_bytes;

    modport source (output valid, output out_word, output byte_count, output last_of_step,
                    output row_done, output row_bytes, input ready);
    modport sink (input valid, input out_word, input byte_count, input last_of_step,
                  input row_done, input row_bytes, output ready);
endinterface

@@ hdl/pbre_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module pbre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pbre_ctrl.sv @@
// sequencing state machine of the packbits row encoder
// depends on pbre_pkg; drives pbre_datapath through ctrl_cmd_t / dp_status_t
module pbre_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pbre_pkg::dp_status_t st,
    output pbre_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEC    = 3'd1;
    localparam logic [2:0] S_LHDR   = 3'd2;
    localparam logic [2:0] S_LBYTES = 3'd3;
    localparam logic [2:0] S_RHDR   = 3'd4;
    localparam logic [2:0] S_RVAL   = 3'd5;
    localparam logic [2:0] S_PUSH   = 3'd6;
    localparam logic [2:0] S_END    = 3'd7;

    localparam logic [1:0] STG_DIFF = 2'd0;
    localparam logic [1:0] STG_CAP  = 2'd1;
    localparam logic [1:0] STG_ROW  = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] stg_reg, stg_next;
    logic [2:0] close_target;

    // where closing the open run starts
    assign close_target = st.repeat_close ? (st.lit_nz ? S_LHDR : S_RHDR) : S_PUSH;

    always_comb
    begin
        state_next   = state_reg;
        stg_next     = stg_reg;
        cmd          = '0;
        cmd.emit_sel = pbre_pkg::EMIT_NONE;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    stg_next   = STG_DIFF;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (stg_reg) inside
                    STG_DIFF:
                    begin
                        if (st.diff_close)
                        begin
                            state_next = close_target;
                        end
                        else
                        begin
                            cmd.upd = 1'b1;
                            if (st.cap_next)
                            begin
                                stg_next = STG_CAP;
                            end
                            else if (st.last)
                            begin
                                stg_next = STG_ROW;
                            end
                            else
                            begin
                                state_next = S_END;
                            end
                        end
                    end
                    STG_CAP, STG_ROW:
                    begin
                        if (st.run_nz)
                        begin
                            state_next = close_target;
                        end
                        else if (st.lit_nz)
                        begin
                            state_next = S_LHDR;
                        end
                        else
                        begin
                            cmd.grp_clr = 1'b1;
                            if (stg_reg == STG_CAP && st.last)
                            begin
                                stg_next = STG_ROW;
                            end
                            else
                            begin
                                state_next = S_END;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_END;
                    end
                endcase
            end
            S_LHDR:
            begin
                cmd.emit_sel = pbre_pkg::EMIT_LHDR;
                if (st.emit_ok)
                begin
                    state_next = S_LBYTES;
                end
            end
            S_LBYTES:
            begin
                cmd.emit_sel = pbre_pkg::EMIT_LBYTE;
                if (st.emit_ok && st.lb_last)
                begin
                    state_next = S_DEC;
                end
            end
            S_RHDR:
            begin
                cmd.emit_sel = pbre_pkg::EMIT_RHDR;
                if (st.emit_ok)
                begin
                    state_next = S_RVAL;
                end
            end
            S_RVAL:
            begin
                cmd.emit_sel = pbre_pkg::EMIT_RVAL;
                if (st.emit_ok)
                begin
                    state_next = S_DEC;
                end
            end
            S_PUSH:
            begin
                cmd.push = 1'b1;
                if (st.push_last)
                begin
                    state_next = S_DEC;
                end
            end
            S_END:
            begin
                cmd.finish = 1'b1;
                if (st.end_done)
                begin
                    // next item may enter while the last word goes out
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.latch  = 1'b1;
                        stg_next   = STG_DIFF;
                        state_next = S_DEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stg_reg   <= STG_DIFF;
        end
        else
        begin
            state_reg <= state_next;
            stg_reg   <= stg_next;
        end
    end

endmodule

@@ hdl/pbre_datapath.sv @@
// run tracking, literal store, byte packer and output register of the encoder
// depends on pbre_pkg and pbre_ram
module pbre_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pbre_pkg::byte_t      in_byte,
    input  logic                 in_last,
    input  pbre_pkg::ctrl_cmd_t  cmd,
    output pbre_pkg::dp_status_t st,
    input  logic                 out_ready,
    output logic                 out_valid,
    output pbre_pkg::word_t      out_word,
    output pbre_pkg::bcnt_t      byte_count,
    output logic                 last_of_step,
    output logic                 row_done,
    output pbre_pkg::row_t       row_bytes
);

    pbre_pkg::byte_t byte_reg;
    logic            last_reg;
    pbre_pkg::byte_t run_val_reg;
    pbre_pkg::cnt_t  run_len_reg;
    pbre_pkg::cnt_t  group_reg;
    logic            mode_reg;
    pbre_pkg::cnt_t  lit_cnt_reg;
    pbre_pkg::addr_t lb_idx_reg;
    pbre_pkg::row_t  row_total_reg;

    pbre_pkg::word_t pk_word_reg;
    pbre_pkg::word_t pk_word_next;
    pbre_pkg::bcnt_t pk_cnt_reg;

    logic            out_valid_reg;
    pbre_pkg::word_t out_word_reg;
    pbre_pkg::bcnt_t out_cnt_reg;
    logic            out_los_reg;
    logic            out_rd_reg;
    pbre_pkg::row_t  out_rb_reg;

    logic            emit_req;
    logic            pk_full;
    logic            out_free;
    logic            emit_ok;
    logic            end_done;
    logic            spill;
    logic            fin;
    logic            lb_last;
    pbre_pkg::byte_t emit_byte;
    pbre_pkg::byte_t ram_rdata;
    pbre_pkg::addr_t ram_raddr;
    pbre_pkg::word_t pk_base;

    assign emit_req = (cmd.emit_sel != pbre_pkg::EMIT_NONE);
    assign pk_full  = (pk_cnt_reg == pbre_pkg::BCNT_W'(pbre_pkg::LANES));
    assign out_free = !out_valid_reg || out_ready;
    // a full packer word only leaves when the next byte arrives, so the
    // step's final word is always still here at the end
    assign emit_ok  = emit_req && (!pk_full || out_free);
    assign spill    = emit_ok && pk_full;
    assign end_done = (pk_cnt_reg == '0) || out_free;
    assign fin      = cmd.finish && end_done && (pk_cnt_reg != '0);
    assign lb_last  = (pbre_pkg::CNT_W'(lb_idx_reg) + pbre_pkg::CNT_W'(1)) == lit_cnt_reg;

    always_comb
    begin
        unique case (cmd.emit_sel)
            pbre_pkg::EMIT_LHDR:  emit_byte = pbre_pkg::byte_t'(lit_cnt_reg) - 8'd1;
            pbre_pkg::EMIT_LBYTE: emit_byte = ram_rdata;
            pbre_pkg::EMIT_RHDR:  emit_byte = 8'd1 - pbre_pkg::byte_t'(run_len_reg);
            pbre_pkg::EMIT_RVAL:  emit_byte = run_val_reg;
            default:              emit_byte = '0;
        endcase
    end

    // read ahead one literal; hold the address while the packer stalls
    always_comb
    begin
        if (cmd.emit_sel == pbre_pkg::EMIT_LBYTE)
        begin
            ram_raddr = emit_ok ? lb_idx_reg + pbre_pkg::ADDR_W'(1) : lb_idx_reg;
        end
        else
        begin
            ram_raddr = '0;
        end
    end

    pbre_ram #(
        .WIDTH (pbre_pkg::BYTE_W),
        .DEPTH (pbre_pkg::MAX_RUN)
    ) u_lit_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (lit_cnt_reg[pbre_pkg::ADDR_W-1:0]),
        .wdata (run_val_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pk_base = ((pk_cnt_reg == '0) || pk_full) ? '0 : pk_word_reg;

    always_comb
    begin
        pk_word_next = pk_base;
        pk_word_next[pk_cnt_reg[pbre_pkg::LANE_W-1:0]*pbre_pkg::BYTE_W +: pbre_pkg::BYTE_W]
            = emit_byte;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            byte_reg <= in_byte;
        end
        if (emit_ok)
        begin
            pk_word_reg <= pk_word_next;
        end
        if (spill || fin)
        begin
            out_word_reg <= pk_word_reg;
            out_cnt_reg  <= pk_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= 1'b0;
            run_val_reg   <= '0;
            run_len_reg   <= '0;
            group_reg     <= '0;
            mode_reg      <= 1'b0;
            lit_cnt_reg   <= '0;
            lb_idx_reg    <= '0;
            row_total_reg <= '0;
            pk_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_los_reg   <= 1'b0;
            out_rd_reg    <= 1'b0;
            out_rb_reg    <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                last_reg <= in_last;
            end

            if (cmd.upd)
            begin
                run_val_reg <= byte_reg;
                run_len_reg <= run_len_reg + pbre_pkg::CNT_W'(1);
                group_reg   <= group_reg + pbre_pkg::CNT_W'(1);
            end
            else if (cmd.push)
            begin
                lit_cnt_reg <= lit_cnt_reg + pbre_pkg::CNT_W'(1);
                run_len_reg <= run_len_reg - pbre_pkg::CNT_W'(1);
                if (run_len_reg == pbre_pkg::CNT_W'(1))
                begin
                    mode_reg <= 1'b1;
                end
            end
            else if (cmd.grp_clr)
            begin
                group_reg <= '0;
                mode_reg  <= 1'b0;
            end
            else if (emit_ok)
            begin
                unique case (cmd.emit_sel)
                    pbre_pkg::EMIT_LHDR:
                    begin
                        lb_idx_reg <= '0;
                    end
                    pbre_pkg::EMIT_LBYTE:
                    begin
                        lb_idx_reg <= lb_idx_reg + pbre_pkg::ADDR_W'(1);
                        if (lb_last)
                        begin
                            lit_cnt_reg <= '0;
                        end
                    end
                    pbre_pkg::EMIT_RVAL:
                    begin
                        run_len_reg <= '0;
                        mode_reg    <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (emit_ok)
            begin
                row_total_reg <= row_total_reg + pbre_pkg::ROW_W'(1);
                pk_cnt_reg    <= pk_full ? pbre_pkg::BCNT_W'(1)
                                         : pk_cnt_reg + pbre_pkg::BCNT_W'(1);
            end
            else if (cmd.finish && end_done)
            begin
                pk_cnt_reg <= '0;
                if (last_reg)
                begin
                    row_total_reg <= '0;
                end
            end

            if (spill || fin)
            begin
                out_valid_reg <= 1'b1;
                out_los_reg   <= fin;
                out_rd_reg    <= fin && last_reg;
                out_rb_reg    <= (fin && last_reg) ? row_total_reg : '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.diff_close   = (run_len_reg != '0) && (byte_reg != run_val_reg);
    assign st.run_nz       = (run_len_reg != '0);
    assign st.repeat_close = (run_len_reg >= pbre_pkg::CNT_W'(3))
                           || ((run_len_reg == pbre_pkg::CNT_W'(2)) && !mode_reg);
    assign st.lit_nz       = (lit_cnt_reg != '0);
    assign st.cap_next     = (group_reg >= pbre_pkg::CNT_W'(pbre_pkg::MAX_RUN - 1));
    assign st.last         = last_reg;
    assign st.lb_last      = lb_last;
    assign st.push_last    = (run_len_reg == pbre_pkg::CNT_W'(1));
    assign st.emit_ok      = emit_ok;
    assign st.end_done     = end_done;

    assign out_valid    = out_valid_reg;
    assign out_word     = out_word_reg;
    assign byte_count   = out_cnt_reg;
    assign last_of_step = out_los_reg;
    assign row_done     = out_rd_reg;
    assign row_bytes    = out_rb_reg;

endmodule

@@ hdl/packbits_row_encoder_top.sv @@
// channel     | dir | payload                                              | item
// byte_ch     | in  | data_byte[7:0], last_in_row                          | one pixel byte
// word_ch     | out | out_word[31:0], byte_count[2:0], last_of_step,       | up to four
//             |     | row_done, row_bytes[15:0]                            | encoded bytes
//
// a byte that closes nothing goes from decode straight to finish, which takes in the next byte
// closing a run pushes each byte to the literal store or emits a repeat header and value,
// a literal flush emits its header and then each stored byte, each then followed by a new decision
// a group cap or a row end adds a decision of its own
// the packer emits one byte per cycle; a full word waiting on word_ch stalls it
// rst_n clears all control state at once; the literal store is never cleared
// depends on pbre_pkg, pbre_in_if, pbre_out_if, pbre_ctrl, pbre_datapath
module packbits_row_encoder_top (
    input logic        clk,
    input logic        rst_n,
    pbre_in_if.sink    byte_ch,
    pbre_out_if.source word_ch
);

    pbre_pkg::ctrl_cmd_t  cmd;
    pbre_pkg::dp_status_t st;
    logic                 ready;

    pbre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_ch.valid),
        .in_ready (ready),
        .st       (st),
        .cmd      (cmd)
    );

    pbre_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (byte_ch.data_byte),
        .in_last      (byte_ch.last_in_row),
        .cmd          (cmd),
        .st           (st),
        .out_ready    (word_ch.ready),
        .out_valid    (word_ch.valid),
        .out_word     (word_ch.out_word),
        .byte_count   (word_ch.byte_count),
        .last_of_step (word_ch.last_of_step),
        .row_done     (word_ch.row_done),
        .row_bytes    (word_ch.row_bytes)
    );

    assign byte_ch.ready = ready;

endmodule

@@ hdl/pbre_checker.sv @@
// port-level checks of the packbits row encoder, bound to the top level
// depends on pbre_pkg and packbits_row_encoder_top_assert.svh
`include "packbits_row_encoder_top_assert.svh"

module pbre_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input pbre_pkg::word_t out_word,
    input pbre_pkg::bcnt_t byte_count,
    input logic            last_of_step,
    input logic            row_done,
    input pbre_pkg::row_t  row_bytes
);

    // every item the encoder takes needs more work, so ready drops once it is taken
    `PBRE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after an item was taken")
    `PBRE_ASSERT_NOW(a_count_range, clk, rst_n, out_valid, (byte_count != '0) && (byte_count <= pbre_pkg::BCNT_W'(pbre_pkg::LANES)), "byte count out of range")
    `PBRE_ASSERT_NOW(a_row_done_final, clk, rst_n, out_valid && row_done, last_of_step, "row end on a word that does not close the step")
    `PBRE_ASSERT_NOW(a_row_bytes_zero, clk, rst_n, out_valid && !row_done, row_bytes == '0, "row count shown outside row end")
    `PBRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word) && $stable(byte_count), "stalled item changed")

endmodule

bind packbits_row_encoder_top pbre_checker u_pbre_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (byte_ch.valid),
    .in_ready     (byte_ch.ready),
    .out_valid    (word_ch.valid),
    .out_ready    (word_ch.ready),
    .out_word     (word_ch.out_word),
    .byte_count   (word_ch.byte_count),
    .last_of_step (word_ch.last_of_step),
    .row_done     (word_ch.row_done),
    .row_bytes    (word_ch.row_bytes)
);
